>>> src/cpst_pkg.sv
package cpst_pkg;

   localparam int DEF_MAX_FFT_LENGTH = 2048;
   localparam int DEF_HISTORY_DEPTH  = 4096;
   localparam int DEF_SAMPLE_BITS    = 16;

   localparam int WORD_W   = 16;
   localparam int FFT_W    = 12;
   localparam int FREEZE_W = 32;
   localparam int POS_W    = 14;
   localparam int CSR_W    = 32;
   localparam int SUM_W    = 40;
   localparam int METRIC_W = 64;

   localparam logic [FFT_W-1:0]    RESET_FFT_LENGTH = FFT_W'(2048);
   localparam logic [FREEZE_W-1:0] RESET_FREEZE     = FREEZE_W'(100000);
   localparam logic [FFT_W-1:0]    MIN_FFT_LENGTH   = FFT_W'(128);

   // prefix lengths are 144/2048 and 160/2048 of the FFT size
   localparam int CPL_MUL  = 9;
   localparam int CPL0_MUL = 5;
   localparam int CPL_SH   = 7;
   localparam int CPL0_SH  = 6;

   localparam logic REG_FFT_LENGTH = 1'b0;
   localparam logic REG_FREEZE     = 1'b1;

   typedef struct packed {
      logic signed [WORD_W-1:0] q;
      logic signed [WORD_W-1:0] i;
   } word_type;

endpackage

>>> src/cpst_front.sv
module cpst_front #(
   parameter int SAMPLE_BITS = cpst_pkg::DEF_SAMPLE_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic signed [cpst_pkg::WORD_W-1:0]  req_sample_i,
   input  logic signed [cpst_pkg::WORD_W-1:0]  req_sample_q,
   output logic                                word_valid,
   output cpst_pkg::word_type                  word_data,
   input  logic                                word_take
);
   localparam int SH = cpst_pkg::WORD_W - SAMPLE_BITS;

   cpst_pkg::word_type slot_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push_ok;
   cpst_pkg::word_type ext;

   // keep low SAMPLE_BITS bits as two's complement
   assign ext.i = $signed(req_sample_i <<< SH) >>> SH;
   assign ext.q = $signed(req_sample_q <<< SH) >>> SH;

   assign push_ok    = req_push && !req_full;
   assign req_full   = (cnt_ff == 2'd2);
   assign word_valid = (cnt_ff != 2'd0);
   assign word_data  = slot_ff[rd_ff];

   always_comb begin
      wr_in  = push_ok ? !wr_ff : wr_ff;
      rd_in  = word_take ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(push_ok) - 2'(word_take);
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[wr_ff] <= ext;
      end
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

>>> src/cpst_back.sv
module cpst_back #(
   parameter int MAX_FFT_LENGTH = cpst_pkg::DEF_MAX_FFT_LENGTH,
   parameter int HISTORY_DEPTH  = cpst_pkg::DEF_HISTORY_DEPTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic                                  csr_index,
   input  logic [cpst_pkg::CSR_W-1:0]            csr_wdata,
   input  logic                                  word_valid,
   input  cpst_pkg::word_type                    word_data,
   output logic                                  word_take,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output logic signed [cpst_pkg::WORD_W-1:0]    rsp_pass_i,
   output logic signed [cpst_pkg::WORD_W-1:0]    rsp_pass_q,
   output logic [cpst_pkg::POS_W-1:0]            rsp_symbol_position,
   output logic                                  rsp_new_peak,
   output logic                                  rsp_metric_valid
);
   localparam int AW = $clog2(HISTORY_DEPTH);
   localparam int NW = $clog2(HISTORY_DEPTH + 1);
   localparam int PW = cpst_pkg::POS_W;
   localparam int SW = cpst_pkg::SUM_W;
   localparam int W  = cpst_pkg::WORD_W;

   localparam logic [3:0] ST_IDLE = 4'd0, ST_PHASE = 4'd1, ST_RDA = 4'd2, ST_RDB = 4'd3,
                          ST_RDC = 4'd4, ST_MULA = 4'd5, ST_MULB = 4'd6, ST_SUBB = 4'd7,
                          ST_MAG = 4'd8, ST_SQR = 4'd9, ST_SUM = 4'd10, ST_DONE = 4'd11;

   logic [3:0] st_ff, st_in;

   // history memory
   cpst_pkg::word_type mem [HISTORY_DEPTH];
   cpst_pkg::word_type rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic [AW:0]   diff;
   logic [AW:0]   back_k;

   // configuration
   logic [cpst_pkg::FFT_W-1:0]    fft_ff;
   logic [7:0]                    cpl_ff;
   logic [PW-1:0]                 slotl_ff;
   logic [cpst_pkg::FREEZE_W-1:0] freeze_ff;
   logic [cpst_pkg::FFT_W-1:0]    f_clamp;
   logic [15:0]                   cpl_wide, cpl0_wide;
   logic [PW:0]                   slotl_calc;

   // per-item state
   logic [AW-1:0]                 wp_ff;
   logic [NW-1:0]                 fill_ff;
   logic [31:0]                   seen_ff;
   logic [PW-1:0]                 phase_ff;
   cpst_pkg::word_type            cur_ff, a_ff, b_ff;
   logic signed [2*W-1:0]         p0_ff, p1_ff, p2_ff, p3_ff;
   logic signed [SW-1:0]          sre_ff, sim_ff;
   logic [SW-1:0]                 mre_ff, mim_ff;
   logic [SW-1:0]                 hh_ff, mm_ff;
   logic [SW:0]                   ll_ff;
   logic [cpst_pkg::METRIC_W-1:0] metric_ff, best_ff;
   logic [PW-1:0]                 best_pos_ff;
   logic                          out_valid_ff;

   logic signed [SW-1:0]  term_re, term_im;
   cpst_pkg::word_type    mx, my;
   logic                  have_a, have_b, valid_now, peak, can_load;
   logic [PW:0]           pos_raw, pos_red;
   logic [SW/2-1:0]       ah, al, bh, bl;

   always_comb begin
      f_clamp = csr_wdata[cpst_pkg::FFT_W-1:0];
      if (f_clamp < cpst_pkg::MIN_FFT_LENGTH) begin
         f_clamp = cpst_pkg::MIN_FFT_LENGTH;
      end else if (f_clamp > cpst_pkg::FFT_W'(MAX_FFT_LENGTH)) begin
         f_clamp = cpst_pkg::FFT_W'(MAX_FFT_LENGTH);
      end
      cpl_wide   = (16'(f_clamp) * 16'(cpst_pkg::CPL_MUL)) >> cpst_pkg::CPL_SH;
      cpl0_wide  = (16'(f_clamp) * 16'(cpst_pkg::CPL0_MUL)) >> cpst_pkg::CPL0_SH;
      slotl_calc = (PW+1)'(f_clamp) * (PW+1)'(7) + (PW+1)'(cpl_wide[7:0]) * (PW+1)'(6)
                   + (PW+1)'(cpl0_wide[7:0]);
   end

   // read address: a step back from the write pointer
   always_comb begin
      case (st_ff)
         ST_RDA:  back_k = (AW+1)'(fft_ff);
         ST_RDB:  back_k = (AW+1)'(fft_ff) + (AW+1)'(cpl_ff);
         default: back_k = (AW+1)'(cpl_ff);
      endcase
      diff = {1'b0, wp_ff} - back_k;
      if (diff[AW]) begin
         diff = diff + (AW+1)'(HISTORY_DEPTH);
      end
      rd_addr = diff[AW-1:0];
   end

   assign have_a   = (NW+1)'(fill_ff) >= (NW+1)'(fft_ff);
   assign have_b   = (NW+1)'(fill_ff) >= (NW+1)'(fft_ff) + (NW+1)'(cpl_ff);
   assign valid_now = (NW+1)'(fill_ff) + (NW+1)'(1) >= (NW+1)'(fft_ff) + (NW+1)'(cpl_ff);
   assign peak     = valid_now && (seen_ff < freeze_ff) && (metric_ff > best_ff);
   assign can_load = !out_valid_ff || rsp_pop;

   // x * conj(y) operands
   always_comb begin
      if (st_ff == ST_MULA) begin
         mx = a_ff;
         my = cur_ff;
      end else begin
         mx = b_ff;
         my = rd_data_ff;
      end
      term_re = SW'(p0_ff) + SW'(p1_ff);
      term_im = SW'(p2_ff) - SW'(p3_ff);
      ah = mre_ff[SW-1:SW/2];
      al = mre_ff[SW/2-1:0];
      bh = mim_ff[SW-1:SW/2];
      bl = mim_ff[SW/2-1:0];
      pos_raw = (PW+1)'(phase_ff) + (PW+1)'(slotl_ff)
                - ((PW+1)'(fft_ff) + (PW+1)'(cpl_ff) - (PW+1)'(1));
      pos_red = (pos_raw >= (PW+1)'(slotl_ff)) ? pos_raw - (PW+1)'(slotl_ff) : pos_raw;
   end

   always_comb begin
      st_in     = st_ff;
      word_take = 1'b0;
      case (st_ff)
         ST_IDLE: begin
            if (word_valid) begin
               word_take = 1'b1;
               st_in     = ST_PHASE;
            end
         end
         ST_PHASE: if (phase_ff < slotl_ff) st_in = ST_RDA;
         ST_RDA:   st_in = ST_RDB;
         ST_RDB:   st_in = ST_RDC;
         ST_RDC:   st_in = ST_MULA;
         ST_MULA:  st_in = ST_MULB;
         ST_MULB:  st_in = ST_SUBB;
         ST_SUBB:  st_in = ST_MAG;
         ST_MAG:   st_in = ST_SQR;
         ST_SQR:   st_in = ST_SUM;
         ST_SUM:   st_in = ST_DONE;
         ST_DONE:  if (can_load) st_in = ST_IDLE;
         default:  st_in = ST_IDLE;
      endcase
   end

   // memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (st_ff == ST_RDA) begin
         mem[wp_ff] <= cur_ff;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (word_take) cur_ff <= word_data;
      if (st_ff == ST_RDB) a_ff <= rd_data_ff;
      if (st_ff == ST_RDC) b_ff <= rd_data_ff;
      p0_ff <= mx.i * my.i;
      p1_ff <= mx.q * my.q;
      p2_ff <= mx.q * my.i;
      p3_ff <= mx.i * my.q;
      mre_ff <= sre_ff[SW-1] ? SW'(-sre_ff) : SW'(sre_ff);
      mim_ff <= sim_ff[SW-1] ? SW'(-sim_ff) : SW'(sim_ff);
      hh_ff <= SW'(ah) * SW'(ah) + SW'(bh) * SW'(bh);
      mm_ff <= SW'(ah) * SW'(al) + SW'(bh) * SW'(bl);
      ll_ff <= (SW+1)'(al) * (SW+1)'(al) + (SW+1)'(bl) * (SW+1)'(bl);
      metric_ff <= ({24'd0, hh_ff} << 24) + ({23'd0, mm_ff, 1'b0} << 4)
                   + cpst_pkg::METRIC_W'(ll_ff >> 16);
   end

   // control and state
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         fft_ff       <= cpst_pkg::RESET_FFT_LENGTH;
         cpl_ff       <= 8'd144;
         slotl_ff     <= PW'(15360);
         freeze_ff    <= cpst_pkg::RESET_FREEZE;
         wp_ff        <= '0;
         fill_ff      <= '0;
         seen_ff      <= '0;
         phase_ff     <= '0;
         sre_ff       <= '0;
         sim_ff       <= '0;
         best_ff      <= '0;
         best_pos_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         // load a new result word, or drop the one just popped
         if (st_ff == ST_DONE && can_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_we && csr_index == cpst_pkg::REG_FFT_LENGTH) begin
            fft_ff   <= f_clamp;
            cpl_ff   <= cpl_wide[7:0];
            slotl_ff <= slotl_calc[PW-1:0];
            sre_ff   <= '0;
            sim_ff   <= '0;
            fill_ff  <= '0;
         end else if (csr_we && csr_index == cpst_pkg::REG_FREEZE) begin
            freeze_ff <= csr_wdata;
         end
         case (st_ff)
            ST_PHASE: if (phase_ff >= slotl_ff) phase_ff <= phase_ff - slotl_ff;
            ST_MULB: begin
               if (have_a) begin
                  sre_ff <= sre_ff + term_re;
                  sim_ff <= sim_ff + term_im;
               end
            end
            ST_SUBB: begin
               if (have_b) begin
                  sre_ff <= sre_ff - term_re;
                  sim_ff <= sim_ff - term_im;
               end
            end
            ST_DONE: begin
               if (can_load) begin
                  if (peak) begin
                     best_ff     <= metric_ff;
                     best_pos_ff <= pos_red[PW-1:0];
                  end
                  rsp_pass_i          <= cur_ff.i;
                  rsp_pass_q          <= cur_ff.q;
                  rsp_symbol_position <= peak ? pos_red[PW-1:0] : best_pos_ff;
                  rsp_new_peak        <= peak;
                  rsp_metric_valid    <= valid_now;
                  wp_ff   <= (wp_ff == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_ff + AW'(1);
                  if (fill_ff < NW'(HISTORY_DEPTH)) fill_ff <= fill_ff + NW'(1);
                  if (seen_ff != '1) seen_ff <= seen_ff + 32'd1;
                  phase_ff <= (phase_ff + PW'(1) >= slotl_ff) ? '0 : phase_ff + PW'(1);
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_empty = !out_valid_ff;

endmodule

>>> src/cp_correlation_symbol_timing_core.sv
// channel | direction | handshake          | payload
// req     | in        | req_push / req_full | req_sample_i, req_sample_q
// rsp     | out       | rsp_pop / rsp_empty | rsp_pass_i/q, rsp_symbol_position,
//         |           |                     | rsp_new_peak, rsp_metric_valid
// csr     | in        | csr_we              | csr_index, csr_wdata
//
// Each word passes the back sequencer in steps: three reads of the single
// history memory port, two multiply/accumulate steps, and a split 20-bit squaring.
// After a shorter FFT size the slot phase is folded back by repeated subtraction.
// A two-word input queue and one result register let each side stall on its own.
// Reset is synchronous; history memory is not cleared (the fill count guards it).
module cp_correlation_symbol_timing_core #(
   parameter int MAX_FFT_LENGTH = cpst_pkg::DEF_MAX_FFT_LENGTH,
   parameter int HISTORY_DEPTH  = cpst_pkg::DEF_HISTORY_DEPTH,
   parameter int SAMPLE_BITS    = cpst_pkg::DEF_SAMPLE_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic signed [cpst_pkg::WORD_W-1:0] req_sample_i,
   input  logic signed [cpst_pkg::WORD_W-1:0] req_sample_q,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic signed [cpst_pkg::WORD_W-1:0] rsp_pass_i,
   output logic signed [cpst_pkg::WORD_W-1:0] rsp_pass_q,
   output logic [cpst_pkg::POS_W-1:0]         rsp_symbol_position,
   output logic                               rsp_new_peak,
   output logic                               rsp_metric_valid,
   input  logic                               csr_we,
   input  logic                               csr_index,
   input  logic [cpst_pkg::CSR_W-1:0]         csr_wdata
);
   logic               word_valid, word_take;
   cpst_pkg::word_type word_data;

   // accept and sign-fold incoming words
   cpst_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
      .clock, .reset, .req_push, .req_full, .req_sample_i, .req_sample_q,
      .word_valid, .word_data, .word_take
   );

   // correlate, search peak, hold result
   cpst_back #(.MAX_FFT_LENGTH(MAX_FFT_LENGTH), .HISTORY_DEPTH(HISTORY_DEPTH)) u_back (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata,
      .word_valid, .word_data, .word_take,
      .rsp_empty, .rsp_pop, .rsp_pass_i, .rsp_pass_q, .rsp_symbol_position,
      .rsp_new_peak, .rsp_metric_valid
   );

   // a peak needs a full window
   a_peak_valid: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (!rsp_new_peak || rsp_metric_valid)) else $error("peak without window");

   // position stays inside the longest slot
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_symbol_position < cpst_pkg::POS_W'(15360)))
      else $error("position out of range");

   // reset leaves no word waiting
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result after reset");

endmodule
